@@ design/sorted_alarm_timer_queue_assert.svh @@
// assertion macros for the sorted alarm timer queue checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define SATQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("satq assertion failed");

// next-cycle implication
`define SATQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("satq assertion failed");

`endif

@@ design/satq_pkg.sv @@
// shared types and constants for the sorted alarm timer queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package satq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 32;
  localparam int TAG_W       = 16;
  localparam int DELAY_W     = 16;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS);
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_POP
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]  expiry;
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] delay;
  } entry_t;

  typedef struct packed {
    logic               ins;
    logic               pop;
    logic [COUNT_W-1:0] count;
    entry_t             ent;
  } chain_ctl_t;

  typedef struct packed {
    entry_t            head;
    logic [TIME_W-1:0] next_expiry;
  } chain_sts_t;

endpackage

`default_nettype wire

@@ design/satq_cell.sv @@
// one slot of the sorted alarm chain: holds an entry, shifts right on insert
// and left on pop; depends on satq_pkg
`timescale 1ns / 1ps
`default_nettype none

module satq_cell (
  input  wire logic            clk,
  input  wire logic            ins,
  input  wire logic            pop,
  input  wire logic            occ,
  input  wire logic            left_ge,
  input  wire satq_pkg::entry_t new_ent,
  input  wire satq_pkg::entry_t left_ent,
  input  wire satq_pkg::entry_t right_ent,
  output logic                 ge,
  output satq_pkg::entry_t     ent_q
);

  satq_pkg::entry_t ent_r;
  satq_pkg::entry_t ent_nxt;

  // empty slots count as later than any new alarm
  assign ge = !occ || (ent_r.expiry >= new_ent.expiry);

  always_comb begin
    ent_nxt = ent_r;
    if (ins) begin
      if (left_ge) begin
        ent_nxt = left_ent;
      end else if (ge) begin
        ent_nxt = new_ent;
      end
    end else if (pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_q = ent_r;

endmodule

`default_nettype wire

@@ design/satq_chain.sv @@
// row of satq_cell slots kept sorted by expiry, head at slot zero
// depends on satq_pkg and satq_cell
`timescale 1ns / 1ps
`default_nettype none

module satq_chain (
  input  wire logic                 clk,
  input  wire satq_pkg::chain_ctl_t ctl,
  output satq_pkg::chain_sts_t      sts
);

  satq_pkg::entry_t ent_q [satq_pkg::QUEUE_DEPTH];
  logic             ge    [satq_pkg::QUEUE_DEPTH];

  for (genvar g = 0; g < satq_pkg::QUEUE_DEPTH; g++) begin : g_cell
    logic             occ;
    logic             left_ge;
    satq_pkg::entry_t left_ent;
    satq_pkg::entry_t right_ent;

    assign occ = ctl.count > satq_pkg::COUNT_W'(g);

    if (g == 0) begin : g_first
      assign left_ge  = 1'b0;
      assign left_ent = ctl.ent;
    end else begin : g_mid
      assign left_ge  = ge[g-1];
      assign left_ent = ent_q[g-1];
    end

    if (g == satq_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = ent_q[g];
    end else begin : g_inner
      assign right_ent = ent_q[g+1];
    end

    satq_cell u_cell (
      .clk       (clk),
      .ins       (ctl.ins),
      .pop       (ctl.pop),
      .occ       (occ),
      .left_ge   (left_ge),
      .new_ent   (ctl.ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ge        (ge[g]),
      .ent_q     (ent_q[g])
    );
  end

  assign sts.head        = ent_q[0];
  assign sts.next_expiry = ent_q[1].expiry;

endmodule

`default_nettype wire

@@ design/satq_ctrl.sv @@
// sequencer for the alarm queue: seconds counter, fill count, result register
// depends on satq_pkg
`timescale 1ns / 1ps
`default_nettype none

module satq_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [satq_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [satq_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [satq_pkg::KIND_W-1:0]             out_tuser,
  output logic                                    out_tlast,
  output satq_pkg::chain_ctl_t                    ctl,
  input  wire satq_pkg::chain_sts_t               sts
);

  satq_pkg::state_t                 state_r, state_nxt;
  logic [satq_pkg::TIME_W-1:0]      now_r, now_nxt;
  logic [satq_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [satq_pkg::NRES_W-1:0]      n_r, n_nxt;
  logic                             out_valid_r, out_valid_nxt;
  satq_pkg::kind_t                  out_kind_r, out_kind_nxt;
  logic [satq_pkg::TAG_W-1:0]       out_tag_r, out_tag_nxt;
  logic [satq_pkg::DELAY_W-1:0]     out_delay_r, out_delay_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             out_free;
  logic                             accept;
  logic [satq_pkg::DELAY_W-1:0]     in_delay;
  logic [satq_pkg::TAG_W-1:0]       in_tag;
  logic                             full;
  logic                             head_due;
  logic                             next_due;
  logic                             cap_hit;
  logic                             pop_last;

  assign in_delay = in_tdata[satq_pkg::DELAY_W-1:0];
  assign in_tag   = in_tdata[satq_pkg::DELAY_W +: satq_pkg::TAG_W];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == satq_pkg::ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign full     = count_r == satq_pkg::COUNT_W'(satq_pkg::QUEUE_DEPTH);
  assign head_due = (count_r != '0) && (sts.head.expiry <= now_r);
  assign next_due = (count_r > satq_pkg::COUNT_W'(1)) && (sts.next_expiry <= now_r);
  assign cap_hit  = n_r == satq_pkg::NRES_W'(satq_pkg::MAX_RESULTS - 1);
  assign pop_last = !next_due || cap_hit;

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_delay_nxt = out_delay_r;
    out_last_nxt  = out_last_r;

    ctl.ins          = 1'b0;
    ctl.pop          = 1'b0;
    ctl.count        = count_r;
    ctl.ent.expiry   = now_r + satq_pkg::TIME_W'(in_delay);
    ctl.ent.tag      = in_tag;
    ctl.ent.delay    = in_delay;

    unique case (state_r)
      satq_pkg::ST_IDLE: begin
        if (accept) begin
          if (satq_pkg::cmd_t'(in_tuser) == satq_pkg::CMD_INSERT) begin
            out_valid_nxt = 1'b1;
            out_tag_nxt   = in_tag;
            out_delay_nxt = in_delay;
            if (in_delay == '0) begin
              out_kind_nxt = satq_pkg::KIND_ACCEPTED;
              out_last_nxt = 1'b0;
              state_nxt    = satq_pkg::ST_ZERO;
            end else if (full) begin
              out_kind_nxt = satq_pkg::KIND_REJECTED;
              out_last_nxt = 1'b1;
            end else begin
              ctl.ins      = 1'b1;
              count_nxt    = count_r + satq_pkg::COUNT_W'(1);
              out_kind_nxt = satq_pkg::KIND_ACCEPTED;
              out_last_nxt = 1'b1;
            end
          end else begin
            now_nxt   = now_r + satq_pkg::TIME_W'(1);
            n_nxt     = '0;
            state_nxt = satq_pkg::ST_POP;
          end
        end
      end
      satq_pkg::ST_ZERO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = satq_pkg::KIND_EXPIRED;
          out_last_nxt  = 1'b1;
          state_nxt     = satq_pkg::ST_IDLE;
        end
      end
      satq_pkg::ST_POP: begin
        if (out_free) begin
          if (head_due) begin
            ctl.pop       = 1'b1;
            count_nxt     = count_r - satq_pkg::COUNT_W'(1);
            n_nxt         = n_r + satq_pkg::NRES_W'(1);
            out_valid_nxt = 1'b1;
            out_kind_nxt  = satq_pkg::KIND_EXPIRED;
            out_tag_nxt   = sts.head.tag;
            out_delay_nxt = sts.head.delay;
            out_last_nxt  = pop_last;
            if (pop_last) begin
              state_nxt = satq_pkg::ST_IDLE;
            end
          end else begin
            state_nxt = satq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = satq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= satq_pkg::ST_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_delay_r <= out_delay_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_delay_r, out_tag_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ design/sorted_alarm_timer_queue.sv @@
// top level of the sorted alarm timer queue
// depends on satq_pkg, satq_ctrl and satq_chain
`timescale 1ns / 1ps
`default_nettype none

// Pending alarms sit in a chain of 16 cells sorted by expiry, earliest at
// cell zero, next to a 32-bit seconds counter. For an insert word (in_tuser
// 0) every cell compares its expiry with now + delay at once and the later
// entries shift one cell right; the result word is registered and appears
// in the cycle after acceptance. A zero delay gives an accepted word followed
// by an expired word, and a full queue rejects any other insert. A tick word
// (in_tuser 1) advances the counter, then pops due alarms one at a time while
// the output register is free, since the chain shifts left by one cell per
// pop; out_tlast marks the end of each run, and a tick with nothing due
// gives no word. A new input word is taken once the previous one has
// finished and the output register is free or being drained.
module sorted_alarm_timer_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [satq_pkg::IN_DATA_W-1:0] in_tdata,   // delay_seconds, alarm_tag
  input  wire logic                           in_tuser,   // cmd
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [satq_pkg::OUT_DATA_W-1:0]     out_tdata,  // out_tag, out_delay
  output logic [satq_pkg::KIND_W-1:0]         out_tuser,  // result_kind
  output logic                                out_tlast
);

  satq_pkg::chain_ctl_t ctl;
  satq_pkg::chain_sts_t sts;

  satq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .ctl        (ctl),
    .sts        (sts)
  );

  satq_chain u_chain (
    .clk (clk),
    .ctl (ctl),
    .sts (sts)
  );

endmodule

`default_nettype wire

@@ design/satq_checker.sv @@
// port-level checks for the sorted alarm timer queue, bound to the top level
// depends on satq_pkg and sorted_alarm_timer_queue_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_alarm_timer_queue_assert.svh"

module satq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [satq_pkg::IN_DATA_W-1:0] in_tdata,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [satq_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [satq_pkg::KIND_W-1:0]    out_tuser,
  input wire logic                           out_tlast
);

  logic zero_ins;
  logic out_stall;

  assign zero_ins = in_tvalid && in_tready && (in_tuser == satq_pkg::CMD_INSERT)
                    && (in_tdata[15:0] == 16'd0);
  assign out_stall = out_tvalid && !out_tready;

  // a rejected insert is always the only word of its item
  `SATQ_ASSERT_NOW(a_reject_last, out_tvalid && (out_tuser == satq_pkg::KIND_REJECTED), out_tlast)

  // an accepted word ends its run unless the delay was zero
  `SATQ_ASSERT_NOW(a_accept_last, out_tvalid && (out_tuser == satq_pkg::KIND_ACCEPTED), out_tlast == (out_tdata[31:16] != 16'd0))

  // a zero-delay insert still owes its expired word, so no new input
  `SATQ_ASSERT_NEXT(a_zero_busy, zero_ins, !in_tready)

  // a stalled result word holds
  `SATQ_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind sorted_alarm_timer_queue satq_checker u_satq_checker (.*);

`default_nettype wire

@@ tb/sorted_alarm_timer_queue_checker.sv @@
// checker for the sorted alarm timer queue: tracks accepted input words, keeps its
// own copy of the sorted alarm list and seconds count, and compares every output word
// depends on satq_pkg
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [satq_pkg::IN_DATA_W-1:0]  in_tdata,   // delay_seconds, alarm_tag
  input  wire logic                            in_tuser,   // cmd
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [satq_pkg::OUT_DATA_W-1:0] out_tdata,  // out_tag, out_delay
  input  wire logic [satq_pkg::KIND_W-1:0]     out_tuser,  // result_kind
  input  wire logic                            out_tlast,
  output int                                   mismatches,
  output int                                   outstanding
);

  typedef struct {
    satq_pkg::kind_t              kind;
    logic [satq_pkg::TAG_W-1:0]   tag;
    logic [satq_pkg::DELAY_W-1:0] delay;
    logic                         last;
  } alarm_word_t;

  alarm_word_t                  pending_words[$];
  logic [satq_pkg::TIME_W-1:0]  seconds_now = '0;
  logic [satq_pkg::TIME_W-1:0]  slot_expiry[satq_pkg::QUEUE_DEPTH];
  logic [satq_pkg::TAG_W-1:0]   slot_tag[satq_pkg::QUEUE_DEPTH];
  logic [satq_pkg::DELAY_W-1:0] slot_delay[satq_pkg::QUEUE_DEPTH];
  int                           slot_count = 0;
  int                           bad_words = 0;

  task automatic queue_result(satq_pkg::kind_t kind, logic [satq_pkg::TAG_W-1:0] tag,
                              logic [satq_pkg::DELAY_W-1:0] delay, logic last);
    alarm_word_t w;
    w.kind  = kind;
    w.tag   = tag;
    w.delay = delay;
    w.last  = last;
    pending_words.push_back(w);
  endtask

  task automatic advance_alarms(satq_pkg::cmd_t cmd, logic [satq_pkg::DELAY_W-1:0] delay,
                                logic [satq_pkg::TAG_W-1:0] tag);
    logic [satq_pkg::TIME_W-1:0] due;
    int                          pos;
    int                          popped;
    int                          i;
    if (cmd == satq_pkg::CMD_INSERT) begin
      if (delay == '0) begin
        queue_result(satq_pkg::KIND_ACCEPTED, tag, delay, 1'b0);
        queue_result(satq_pkg::KIND_EXPIRED, tag, delay, 1'b1);
      end else if (slot_count >= satq_pkg::QUEUE_DEPTH) begin
        queue_result(satq_pkg::KIND_REJECTED, tag, delay, 1'b1);
      end else begin
        due = seconds_now + satq_pkg::TIME_W'(delay);
        // goes ahead of the first entry due at the same time or later
        pos = slot_count;
        for (i = slot_count - 1; i >= 0; i--) begin
          if (slot_expiry[i] >= due) pos = i;
        end
        for (i = slot_count; i > pos; i--) begin
          slot_expiry[i] = slot_expiry[i-1];
          slot_tag[i]    = slot_tag[i-1];
          slot_delay[i]  = slot_delay[i-1];
        end
        slot_expiry[pos] = due;
        slot_tag[pos]    = tag;
        slot_delay[pos]  = delay;
        slot_count++;
        queue_result(satq_pkg::KIND_ACCEPTED, tag, delay, 1'b1);
      end
    end else begin
      seconds_now = seconds_now + 1'b1;
      popped = 0;
      while (popped < slot_count && popped < satq_pkg::MAX_RESULTS &&
             slot_expiry[popped] <= seconds_now) begin
        queue_result(satq_pkg::KIND_EXPIRED, slot_tag[popped], slot_delay[popped], 1'b0);
        popped++;
      end
      if (popped > 0) begin
        for (i = popped; i < slot_count; i++) begin
          slot_expiry[i-popped] = slot_expiry[i];
          slot_tag[i-popped]    = slot_tag[i];
          slot_delay[i-popped]  = slot_delay[i];
        end
        slot_count -= popped;
        pending_words[pending_words.size()-1].last = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    alarm_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        advance_alarms(satq_pkg::cmd_t'(in_tuser), in_tdata[satq_pkg::DELAY_W-1:0],
                       in_tdata[satq_pkg::DELAY_W +: satq_pkg::TAG_W]);
      end
      if (out_tvalid && out_tready) begin
        if (pending_words.size() == 0) begin
          if (bad_words < 10) begin
            $display("unexpected word: kind %0d tag %h delay %h last %b",
                     out_tuser, out_tdata[satq_pkg::TAG_W-1:0],
                     out_tdata[satq_pkg::TAG_W +: satq_pkg::DELAY_W], out_tlast);
          end
          bad_words++;
        end else begin
          want = pending_words.pop_front();
          if (out_tuser !== want.kind || out_tdata[satq_pkg::TAG_W-1:0] !== want.tag ||
              out_tdata[satq_pkg::TAG_W +: satq_pkg::DELAY_W] !== want.delay ||
              out_tlast !== want.last) begin
            if (bad_words < 10) begin
              $display({"mismatch: expected kind %0d tag %h delay %h last %b, ",
                        "got kind %0d tag %h delay %h last %b"},
                       want.kind, want.tag, want.delay, want.last, out_tuser,
                       out_tdata[satq_pkg::TAG_W-1:0],
                       out_tdata[satq_pkg::TAG_W +: satq_pkg::DELAY_W], out_tlast);
            end
            bad_words++;
          end
        end
      end
    end
    mismatches  <= bad_words;
    outstanding <= pending_words.size();
  end

endmodule

@@ tb/sorted_alarm_timer_queue_sorted_alarm_timer_queue_tb.sv @@
// testbench top for the sorted alarm timer queue: drives insert and tick words with
// random gaps and back-pressure, and gives the verdict from the checker's count
// depends on satq_pkg, sorted_alarm_timer_queue and sorted_alarm_timer_queue_checker
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_tb;

  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [satq_pkg::IN_DATA_W-1:0]  in_tdata   = '0;   // delay_seconds, alarm_tag
  logic                            in_tuser   = 1'b0; // cmd
  logic                            out_tready = 1'b0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [satq_pkg::OUT_DATA_W-1:0] out_tdata;         // out_tag, out_delay
  logic [satq_pkg::KIND_W-1:0]     out_tuser;         // result_kind
  logic                            out_tlast;

  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  logic stall_toggle = 1'b0;
  logic stall_seen   = 1'b0;
  int   stall_left   = 0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   outstanding;

  sorted_alarm_timer_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sorted_alarm_timer_queue_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random ready, plus a long hold-off each time the toggle flips
  always @(posedge clk) begin
    if (stall_toggle != stall_seen) begin
      stall_seen = stall_toggle;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(satq_pkg::cmd_t cmd, logic [satq_pkg::DELAY_W-1:0] delay,
                           logic [satq_pkg::TAG_W-1:0] tag);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {tag, delay};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_words(int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_word(satq_pkg::CMD_INSERT, '0, satq_pkg::TAG_W'($urandom));
      end else if (roll < 6) begin
        send_word(satq_pkg::CMD_INSERT, satq_pkg::DELAY_W'($urandom_range(160, 32)),
                  satq_pkg::TAG_W'($urandom));
      end else if (roll < 46) begin
        send_word(satq_pkg::CMD_INSERT, satq_pkg::DELAY_W'($urandom_range(31, 1)),
                  satq_pkg::TAG_W'($urandom));
      end else begin
        send_word(satq_pkg::CMD_TICK, satq_pkg::DELAY_W'($urandom),
                  satq_pkg::TAG_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 35;
    rx_idle_pct = 85;

    // tick on empty queue, zero delay, longest delay, equal expiries
    send_word(satq_pkg::CMD_TICK, '0, '0);
    send_word(satq_pkg::CMD_INSERT, 16'h0000, 16'h0000);
    send_word(satq_pkg::CMD_INSERT, 16'hffff, 16'hffff);
    send_word(satq_pkg::CMD_INSERT, 16'd1, 16'h1234);
    send_word(satq_pkg::CMD_INSERT, 16'd2, 16'haaaa);
    send_word(satq_pkg::CMD_INSERT, 16'd2, 16'h5555);
    send_word(satq_pkg::CMD_TICK, '1, '1);
    send_word(satq_pkg::CMD_TICK, '0, '0);
    // fill up, then reject, then zero delay while full
    repeat (15) send_word(satq_pkg::CMD_INSERT, 16'd2, satq_pkg::TAG_W'($urandom));
    send_word(satq_pkg::CMD_INSERT, 16'd7, 16'hbeef);
    send_word(satq_pkg::CMD_INSERT, 16'd0, 16'h0f0f);
    // the whole batch falls due on one tick
    send_word(satq_pkg::CMD_TICK, '0, '0);
    send_word(satq_pkg::CMD_TICK, '0, '0);

    // hold the output side off while inserts keep coming
    stall_toggle <= ~stall_toggle;
    repeat (24) send_word(satq_pkg::CMD_INSERT, satq_pkg::DELAY_W'($urandom_range(31, 1)),
                          satq_pkg::TAG_W'($urandom));

    random_words(125);
    tx_idle_pct = 85;
    rx_idle_pct = 35;
    random_words(125);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_words(125);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
